// File: rtl/bf_pkg.sv
// shared types and constants of the 3x3 rgb box filter
package bf_pkg;

    // one pixel, one byte per channel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // nine samples of 255 plus rounding offset fit in 12 bits
    localparam int SUM_W = 12;

    // floor(x / 9) = (x * RECIP_MULT) >> RECIP_SHIFT, exact for x < 4096
    localparam int RECIP_SHIFT = 15;
    localparam logic [SUM_W-1:0] RECIP_MULT = 12'd3641;
    localparam logic [SUM_W-1:0] ROUND_OFS = 12'd4;
    localparam int PROD_W = 2 * SUM_W;

    // configuration register indexes
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // widths of the configuration registers
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;

    // control of an item leaving the line-store read stage
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } stage_ctl_t;

    // per-channel window sums travelling to the divider
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } sum_word_t;

endpackage

// File: rtl/bf_line_store.sv
// dual line store: one synchronous memory holding upper and middle row per column
module bf_line_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [2*$bits(bf_pkg::pixel_t)-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [2*$bits(bf_pkg::pixel_t)-1:0] wr_data
);
    import bf_pkg::*;

    localparam int ENTRY_W = 2 * $bits(pixel_t);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bf_window.sv
// 3x3 sliding window and per-channel adder tree
module bf_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  bf_pkg::stage_ctl_t  ctl,
    input  bf_pkg::pixel_t      top_pix,
    input  bf_pkg::pixel_t      mid_pix,
    input  bf_pkg::pixel_t      new_pix,
    output bf_pkg::sum_word_t   sum_word
);
    import bf_pkg::*;

    // index row*3+col, row 0 on top, col 2 newest
    pixel_t [8:0] window_reg;
    pixel_t [8:0] window_next;

    logic [SUM_W-1:0] red_next;
    logic [SUM_W-1:0] green_next;
    logic [SUM_W-1:0] blue_next;

    logic             sum_valid_reg;
    logic             sum_last_reg;
    logic [SUM_W-1:0] red_sum_reg;
    logic [SUM_W-1:0] green_sum_reg;
    logic [SUM_W-1:0] blue_sum_reg;

    // shift columns left, new column from the line store and input
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            window_next[k*3+0] = window_reg[k*3+1];
            window_next[k*3+1] = window_reg[k*3+2];
        end
        window_next[2] = top_pix;
        window_next[5] = mid_pix;
        window_next[8] = new_pix;
    end

    // adder tree over the nine samples, by column then across
    always_comb
    begin
        logic [SUM_W-1:0] rc0, rc1, rc2, gc0, gc1, gc2, bc0, bc1, bc2;
        rc0 = SUM_W'(window_next[0].red) + SUM_W'(window_next[3].red)
            + SUM_W'(window_next[6].red);
        rc1 = SUM_W'(window_next[1].red) + SUM_W'(window_next[4].red)
            + SUM_W'(window_next[7].red);
        rc2 = SUM_W'(window_next[2].red) + SUM_W'(window_next[5].red)
            + SUM_W'(window_next[8].red);
        gc0 = SUM_W'(window_next[0].green) + SUM_W'(window_next[3].green)
            + SUM_W'(window_next[6].green);
        gc1 = SUM_W'(window_next[1].green) + SUM_W'(window_next[4].green)
            + SUM_W'(window_next[7].green);
        gc2 = SUM_W'(window_next[2].green) + SUM_W'(window_next[5].green)
            + SUM_W'(window_next[8].green);
        bc0 = SUM_W'(window_next[0].blue) + SUM_W'(window_next[3].blue)
            + SUM_W'(window_next[6].blue);
        bc1 = SUM_W'(window_next[1].blue) + SUM_W'(window_next[4].blue)
            + SUM_W'(window_next[7].blue);
        bc2 = SUM_W'(window_next[2].blue) + SUM_W'(window_next[5].blue)
            + SUM_W'(window_next[8].blue);
        red_next   = rc0 + rc1 + rc2;
        green_next = gc0 + gc1 + gc2;
        blue_next  = bc0 + bc1 + bc2;
    end

    // window moves once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (advance && ctl.valid)
        begin
            window_reg <= window_next;
        end
    end

    // sum stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg <= ctl.valid && ctl.emit;
        end
    end

    // sum stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_last_reg  <= ctl.last;
            red_sum_reg   <= red_next;
            green_sum_reg <= green_next;
            blue_sum_reg  <= blue_next;
        end
    end

    assign sum_word.valid = sum_valid_reg;
    assign sum_word.last  = sum_last_reg;
    assign sum_word.red   = red_sum_reg;
    assign sum_word.green = green_sum_reg;
    assign sum_word.blue  = blue_sum_reg;

endmodule

// File: rtl/bf_mean.sv
// rounded divide by nine and output register
module bf_mean (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  bf_pkg::sum_word_t sum_word,
    output logic              out_valid,
    output bf_pkg::pixel_t    out_pix,
    output logic              out_last
);
    import bf_pkg::*;

    logic   out_valid_reg;
    logic   out_last_reg;
    pixel_t out_pix_reg;
    pixel_t out_pix_next;

    // (sum + 4) / 9 via reciprocal multiply
    function automatic logic [7:0] div9_round(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0]  biased;
        logic [PROD_W-1:0] prod;
        biased = sum + ROUND_OFS;
        prod   = PROD_W'(biased) * PROD_W'(RECIP_MULT);
        return prod[RECIP_SHIFT +: 8];
    endfunction

    always_comb
    begin
        out_pix_next.red   = div9_round(sum_word.red);
        out_pix_next.green = div9_round(sum_word.green);
        out_pix_next.blue  = div9_round(sum_word.blue);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= sum_word.valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pix_reg  <= out_pix_next;
            out_last_reg <= sum_word.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/box_filter_3x3_rgb.sv
// top level of the 3x3 rgb box filter
// 3x3 mean filter over RGB pixels streamed in raster order. One pixel word is
// taken per clock for as long as the output side keeps up; the line-store
// memory is read and written back once per pixel at different columns, so no
// cycle is lost between pixels. A pixel's result, if any, reaches the master
// side through the line-store read, then the window and adder tree, then the
// divide by nine into the output register; a result left waiting there holds
// the whole pipeline and the slave side with it. Results come only for
// interior centres, each channel rounded as (sum+4)/9, and m_tlast marks the
// frame's last result. Width and height are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT; writing either register restarts the frame and must be done
// while the filter is idle. The line store needs no clearing after reset.
module box_filter_3x3_rgb #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // red_in, green_in, blue_in
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // red_out, green_out, blue_out
    output logic                          m_tlast,   // frame_last
    // configuration
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [bf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bf_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PIX_W = $bits(pixel_t);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_last;
    logic [ROW_W-1:0]        row_last;

    logic       advance;
    logic       accept;
    logic       at_row_end;
    logic       at_frame_end;
    pixel_t     in_pix;

    stage_ctl_t       s1_ctl_reg;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;

    logic [2*PIX_W-1:0] rd_data;
    pixel_t             top_pix;
    pixel_t             mid_pix;
    sum_word_t          sum_word;
    logic               out_valid;
    pixel_t             out_pix;
    logic               out_last;

    // whole pipeline moves when the output register is free
    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign in_pix.red   = s_tdata[7:0];
    assign in_pix.green = s_tdata[15:8];
    assign in_pix.blue  = s_tdata[23:16];

    // effective last column and row after clamping
    always_comb
    begin
        if (width_reg < WIDTH_REG_W'(3))
        begin
            col_last = COL_W'(2);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = COL_W'(width_reg - WIDTH_REG_W'(1));
        end

        if (height_reg < HEIGHT_REG_W'(3))
        begin
            row_last = ROW_W'(2);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            row_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_last = ROW_W'(height_reg - HEIGHT_REG_W'(1));
        end
    end

    assign at_row_end   = (col_reg == col_last);
    assign at_frame_end = at_row_end && (row_reg == row_last);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(640);
            height_reg <= HEIGHT_REG_W'(480);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[WIDTH_REG_W-1:0];
            end
            else
            begin
                height_reg <= cfg_data[HEIGHT_REG_W-1:0];
            end
        end
    end

    // raster position of the next pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (at_row_end)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == row_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (advance)
        begin
            s1_ctl_reg.valid <= s_tvalid;
            s1_ctl_reg.emit  <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            s1_ctl_reg.last  <= at_frame_end;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= in_pix;
            s1_col_reg <= col_reg;
        end
    end

    // entry holds {upper row, middle row}; write back shifts the column up
    bf_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (advance && s1_ctl_reg.valid),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_pix, s1_pix_reg})
    );

    assign top_pix = rd_data[2*PIX_W-1:PIX_W];
    assign mid_pix = rd_data[PIX_W-1:0];

    bf_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .ctl      (s1_ctl_reg),
        .top_pix  (top_pix),
        .mid_pix  (mid_pix),
        .new_pix  (s1_pix_reg),
        .sum_word (sum_word)
    );

    bf_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .sum_word  (sum_word),
        .out_valid (out_valid),
        .out_pix   (out_pix),
        .out_last  (out_last)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_pix.blue, out_pix.green, out_pix.red};
    assign m_tlast  = out_last;

endmodule
